// ===== rtl/core/sbce_pkg.sv =====
// ----------------------------------------------------------------------------
// sbce_pkg
// Shared types, constants and helpers of the sensor bank change-event block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbce_pkg;

    localparam int MODULE_W   = 3;   // module index width
    localparam int BYTE_W     = 8;   // contact byte width
    localparam int CONTACT_W  = 5;   // contact number width
    localparam int MASK_W     = 32;  // four groups of eight change bits
    localparam int POS_W      = 5;   // index into the change mask
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Change record handed from front to back.
    // mask[7:0] set in first byte, [15:8] set in second byte,
    // [23:16] cleared in first byte, [31:24] cleared in second byte.
    typedef struct packed {
        logic [MODULE_W-1:0] module_index;
        logic [MASK_W-1:0]   mask;
    } t_change;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [MODULE_W-1:0]  event_module;
        logic [CONTACT_W-1:0] contact_number;
        logic                 released;
        logic                 last_event;
    } t_event;

    // Position of the lowest set bit; zero for an empty mask.
    function automatic logic [POS_W-1:0] f_lsb_index(input logic [MASK_W-1:0] mask);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

    // Contact number for a mask position: 8 minus bit, plus 8 for second byte.
    function automatic logic [CONTACT_W-1:0] f_contact(input logic [POS_W-1:0] pos);
        return CONTACT_W'(8) - {2'b00, pos[2:0]} + {1'b0, pos[3], 3'b000};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbce_if.sv =====
// ----------------------------------------------------------------------------
// sbce_if
// Valid/ready channels for sensor readings and change events.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbce_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] module_index;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, module_index, first_byte, second_byte, input ready);
    modport sink   (input valid, module_index, first_byte, second_byte, output ready);
endinterface

interface sbce_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_module;
    logic [4:0] contact_number;
    logic       released;
    logic       last_event;

    modport source (output valid, event_module, contact_number, released, last_event,
                    input ready);
    modport sink   (input valid, event_module, contact_number, released, last_event,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sbce_front.sv =====
// ----------------------------------------------------------------------------
// sbce_front
// Takes readings, compares against stored contacts, pushes change records.
// ----------------------------------------------------------------------------
`default_nettype none

module sbce_front
    import sbce_pkg::*;
#(
    parameter int NUM_MODULES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [MODULE_W-1:0] i_module_index,
    input  wire logic [BYTE_W-1:0]   i_first_byte,
    input  wire logic [BYTE_W-1:0]   i_second_byte,
    input  wire t_q_status           i_q_status,
    output logic                     o_push,
    output t_change                  o_push_data
);

    // Only indexes reachable through the 3-bit field need storage.
    localparam int DEPTH = (NUM_MODULES < (1 << MODULE_W)) ? NUM_MODULES : (1 << MODULE_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [5:0] NUM_MOD = 6'(NUM_MODULES);

    logic [2*BYTE_W-1:0] r_prev [DEPTH];

    logic                accept;
    logic                in_range;
    logic [IDX_W-1:0]    idx;
    logic [2*BYTE_W-1:0] prev_bits;
    logic [2*BYTE_W-1:0] new_bits;

    assign o_ready   = !i_q_status.full;
    assign accept    = i_valid && o_ready;
    assign in_range  = {3'b000, i_module_index} < NUM_MOD;
    assign idx       = i_module_index[IDX_W-1:0];
    assign prev_bits = in_range ? r_prev[idx] : '0;
    assign new_bits  = {i_second_byte, i_first_byte};

    assign o_push_data.module_index = i_module_index;
    assign o_push_data.mask = {prev_bits & ~new_bits, new_bits & ~prev_bits};
    // unchanged or out-of-range readings produce no record
    assign o_push = accept && in_range && (|o_push_data.mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_prev[i] <= '0;
            end
        end else if (accept && in_range) begin
            r_prev[idx] <= new_bits;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbce_queue.sv =====
// ----------------------------------------------------------------------------
// sbce_queue
// Short FIFO of change records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sbce_queue
    import sbce_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_change i_push_data,
    input  wire logic    i_pop,
    output t_change      o_pop_data,
    output t_q_status    o_status
);

    t_change            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_pop_data     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbce_back.sv =====
// ----------------------------------------------------------------------------
// sbce_back
// Serializes one change record into events, lowest mask bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module sbce_back
    import sbce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q_status,
    input  wire t_change   i_pop_data,
    output logic           o_pop,
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_event         o_event
);

    logic                r_busy;
    logic [MASK_W-1:0]   r_mask;
    logic [MODULE_W-1:0] r_module;
    logic                r_out_valid;
    t_event              r_event;

    logic                fire;
    logic [POS_W-1:0]    pos;
    logic [MASK_W-1:0]   rest;

    assign o_pop       = !r_busy && !i_q_status.empty;
    assign fire        = r_busy && (!r_out_valid || i_out_ready);
    assign pos         = f_lsb_index(r_mask);
    assign rest        = r_mask & (r_mask - 1'b1);
    assign o_out_valid = r_out_valid;
    assign o_event     = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (fire && (rest == '0)) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mask   <= i_pop_data.mask;
            r_module <= i_pop_data.module_index;
        end else if (fire) begin
            r_mask <= rest;
        end
        if (fire) begin
            r_event.event_module   <= r_module;
            r_event.contact_number <= f_contact(pos);
            r_event.released       <= pos[4];
            r_event.last_event     <= (rest == '0);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sensor_bank_change_events.sv =====
// ----------------------------------------------------------------------------
// sensor_bank_change_events
// Turns polled sensor module readings into per-contact change events.
// ----------------------------------------------------------------------------
// Each accepted word is one reading of a module (index plus two contact
// bytes). The front compares it with the stored 16 bits of that module in
// the same cycle, stores the new reading and pushes a 32-bit change record
// into a two-entry queue; readings with no change, or with a module index
// not below NUM_MODULES, leave nothing behind. The back pops a record and
// emits one event word per cycle from its output register while the
// output is not stalled: newly set contacts of the first byte, then the
// second byte, then released contacts of the first byte, then the second,
// lowest bit first within each group, with last_event on the final one.
// A reading with k changed contacts yields k events and keeps the back
// busy until the last is issued, with no new record taken meanwhile; the
// one-event-per-cycle serializer sets the sustained rate. Input is taken
// whenever the queue has room, so unchanged readings go through at one
// per cycle. Reset clears stored contacts directly; no clearing pass needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_bank_change_events
    import sbce_pkg::*;
#(
    parameter int NUM_MODULES = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbce_in_if.sink     i_in,
    sbce_out_if.source  o_out
);

    t_q_status q_status;
    t_change   push_data;
    t_change   pop_data;
    logic      push;
    logic      pop;
    logic      out_valid;
    t_event    out_event;

    // front: classify and record changes
    sbce_front #(
        .NUM_MODULES (NUM_MODULES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_module_index (i_in.module_index),
        .i_first_byte   (i_in.first_byte),
        .i_second_byte  (i_in.second_byte),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    // decouples the input side from output stalls
    sbce_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    // back: one event word per cycle while the output is not stalled
    sbce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_event     (out_event)
    );

    assign o_out.valid          = out_valid;
    assign o_out.event_module   = out_event.event_module;
    assign o_out.contact_number = out_event.contact_number;
    assign o_out.released       = out_event.released;
    assign o_out.last_event     = out_event.last_event;

    // Queue can never report full and empty at once.
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty together");

    // Every event names a contact 1..16.
    a_contact_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.contact_number >= 5'd1 && o_out.contact_number <= 5'd16))
        else $error("contact number out of range");

    // No event word right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("event valid right after reset");

endmodule

`default_nettype wire
